@@ rtl/core/etgb_pkg.sv @@
// ----------------------------------------------------------------------------
// etgb_pkg
// Types, constants and the divider step shared by the edge/texture gain blend.
// ----------------------------------------------------------------------------
package etgb_pkg;

   localparam int LUMA_W      = 8;
   localparam int RESP_W      = 12;
   localparam int MAG_W       = 12;
   localparam int THR_W       = 11;
   localparam int GAIN_W      = 12;
   localparam int PROD_W      = THR_W + GAIN_W;
   localparam int NUM_W       = PROD_W;
   localparam int FRAC_W      = 10;
   localparam int SCALED_W    = LUMA_W + NUM_W;
   localparam int DIVIDEND_W  = SCALED_W - FRAC_W;
   localparam int QUOT_W      = 10;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES  = QUOT_W / BITS_PER_STAGE;
   localparam int SUM_W       = QUOT_W + 1;

   localparam int APB_DATA_W  = 32;
   localparam int APB_ADDR_W  = 4;

   localparam logic [LUMA_W-1:0] LUMA_MAX = 8'd255;

   localparam logic [THR_W-1:0]  EDGE_THR_RESET    = 11'd64;
   localparam logic [THR_W-1:0]  TEXTURE_THR_RESET = 11'd16;
   localparam logic [GAIN_W-1:0] EDGE_GAIN_RESET   = 12'd512;
   localparam logic [GAIN_W-1:0] TEXTURE_GAIN_RESET = 12'd256;

   localparam logic [1:0] REG_EDGE_THR     = 2'd0;
   localparam logic [1:0] REG_TEXTURE_THR  = 2'd1;
   localparam logic [1:0] REG_EDGE_GAIN    = 2'd2;
   localparam logic [1:0] REG_TEXTURE_GAIN = 2'd3;

   typedef enum logic [1:0] {
      MODE_EDGE,
      MODE_BLEND,
      MODE_RAMP,
      MODE_NONE
   } gain_mode_type;

   typedef struct packed {
      logic [DIVIDEND_W-1:0] rem;
      logic [QUOT_W-1:0]     quot;
   } div_state_type;

   typedef struct packed {
      logic [LUMA_W-1:0] luma;
      logic              positive;
      logic              sticky;
      logic [THR_W-1:0]  den;
   } side_type;

   function automatic div_state_type div_step2(input div_state_type cur,
                                               input logic [THR_W-1:0] den,
                                               input int top_bit);
      div_state_type         nxt;
      logic [DIVIDEND_W-1:0] trial;
      nxt = cur;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
         trial = DIVIDEND_W'(den) << (top_bit - j);
         if (nxt.rem >= trial) begin
            nxt.rem  = nxt.rem - trial;
            nxt.quot = {nxt.quot[QUOT_W-2:0], 1'b1};
         end else begin
            nxt.quot = {nxt.quot[QUOT_W-2:0], 1'b0};
         end
      end
      return nxt;
   endfunction

endpackage

@@ rtl/core/edge_texture_gain_blend_unit.sv @@
// ----------------------------------------------------------------------------
// edge_texture_gain_blend_unit
// Throughput: one pixel per cycle; busy is never raised, since the
// ten register stages (gain select, two multiplies, sum, luma scale, five
// two-bit divider stages, clamp) move every cycle and the receiver cannot
// stall. Reset (synchronous) clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module edge_texture_gain_blend_unit
   import etgb_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [LUMA_W-1:0]               req_luma,
   input  logic signed [RESP_W-1:0]        req_edge_response,
   output logic                            rsp_strobe,
   output logic [LUMA_W-1:0]               rsp_enhanced_luma,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [APB_ADDR_W-1:0]           paddr,
   input  logic [APB_DATA_W-1:0]           pwdata,
   output logic [APB_DATA_W-1:0]           prdata,
   output logic                            pready
);

   // configuration registers
   logic [THR_W-1:0]  edge_thr_ff, edge_thr_in;
   logic [THR_W-1:0]  tex_thr_ff, tex_thr_in;
   logic [GAIN_W-1:0] edge_gain_ff, edge_gain_in;
   logic [GAIN_W-1:0] tex_gain_ff, tex_gain_in;
   logic              cfg_write;

   // stage 1: gain selection
   logic              s1_valid_ff, s1_valid_in;
   logic [LUMA_W-1:0] s1_luma_ff, s1_luma_in;
   logic              s1_pos_ff, s1_pos_in;
   gain_mode_type     s1_mode_ff, s1_mode_in;
   logic [THR_W-1:0]  s1_op_a_ff, s1_op_a_in;
   logic [THR_W-1:0]  s1_op_b_ff, s1_op_b_in;
   logic [THR_W-1:0]  s1_den_ff, s1_den_in;
   logic [MAG_W-1:0]  raw;
   logic [MAG_W-1:0]  mag;
   logic              neg;

   // stage 2: products
   logic              s2_valid_ff, s2_valid_in;
   logic [LUMA_W-1:0] s2_luma_ff, s2_luma_in;
   logic              s2_pos_ff, s2_pos_in;
   gain_mode_type     s2_mode_ff, s2_mode_in;
   logic [THR_W-1:0]  s2_den_ff, s2_den_in;
   logic [PROD_W-1:0] s2_prod_a_ff, s2_prod_a_in;
   logic [PROD_W-1:0] s2_prod_b_ff, s2_prod_b_in;

   // stage 3: numerator
   logic              s3_valid_ff, s3_valid_in;
   logic [LUMA_W-1:0] s3_luma_ff, s3_luma_in;
   logic              s3_pos_ff, s3_pos_in;
   logic [THR_W-1:0]  s3_den_ff, s3_den_in;
   logic [NUM_W-1:0]  s3_num_ff, s3_num_in;
   logic [NUM_W:0]    num_sum;

   // stage 4 onwards: scaled luma into the divider
   logic [SCALED_W-1:0] scaled;
   logic          pipe_valid_ff [0:DIV_STAGES];
   logic          pipe_valid_in [0:DIV_STAGES];
   side_type      pipe_side_ff  [0:DIV_STAGES];
   side_type      pipe_side_in  [0:DIV_STAGES];
   div_state_type div_ff        [0:DIV_STAGES];
   div_state_type div_in        [0:DIV_STAGES];

   // output stage
   logic              out_valid_ff, out_valid_in;
   logic [LUMA_W-1:0] out_luma_ff, out_luma_in;
   div_state_type     fin;
   side_type          fin_side;
   logic              inexact;
   logic [SUM_W-1:0]  up_sum;
   logic [SUM_W-1:0]  down_amt;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // ---------------------------------------------------------------- config
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      edge_thr_in  = edge_thr_ff;
      tex_thr_in   = tex_thr_ff;
      edge_gain_in = edge_gain_ff;
      tex_gain_in  = tex_gain_ff;
      if (cfg_write) begin
         case (paddr[3:2])
            REG_EDGE_THR:     edge_thr_in  = pwdata[THR_W-1:0];
            REG_TEXTURE_THR:  tex_thr_in   = pwdata[THR_W-1:0];
            REG_EDGE_GAIN:    edge_gain_in = pwdata[GAIN_W-1:0];
            REG_TEXTURE_GAIN: tex_gain_in  = pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_EDGE_THR:     prdata = APB_DATA_W'(edge_thr_ff);
         REG_TEXTURE_THR:  prdata = APB_DATA_W'(tex_thr_ff);
         REG_EDGE_GAIN:    prdata = APB_DATA_W'(edge_gain_ff);
         REG_TEXTURE_GAIN: prdata = APB_DATA_W'(tex_gain_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_thr_ff  <= EDGE_THR_RESET;
         tex_thr_ff   <= TEXTURE_THR_RESET;
         edge_gain_ff <= EDGE_GAIN_RESET;
         tex_gain_ff  <= TEXTURE_GAIN_RESET;
      end else begin
         edge_thr_ff  <= edge_thr_in;
         tex_thr_ff   <= tex_thr_in;
         edge_gain_ff <= edge_gain_in;
         tex_gain_ff  <= tex_gain_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign raw = req_edge_response;
   assign neg = raw[MAG_W-1];
   assign mag = neg ? MAG_W'(~raw + MAG_W'(1)) : raw;

   always_comb begin
      s1_valid_in = start & ~busy;
      s1_luma_in  = req_luma;
      s1_pos_in   = ~neg & (raw != '0);
      s1_op_a_in  = '0;
      s1_op_b_in  = '0;
      s1_den_in   = THR_W'(1);
      if (mag >= {1'b0, edge_thr_ff}) begin
         s1_mode_in = MODE_EDGE;
      end else if (mag >= {1'b0, tex_thr_ff}) begin
         s1_mode_in = MODE_BLEND;
         s1_op_a_in = THR_W'(mag - {1'b0, tex_thr_ff});
         s1_op_b_in = THR_W'({1'b0, edge_thr_ff} - mag);
         s1_den_in  = edge_thr_ff - tex_thr_ff;
      end else if (tex_thr_ff != '0) begin
         s1_mode_in = MODE_RAMP;
         s1_op_b_in = THR_W'(mag);
         s1_den_in  = tex_thr_ff;
      end else begin
         s1_mode_in = MODE_NONE;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_luma_in   = s1_luma_ff;
      s2_pos_in    = s1_pos_ff;
      s2_mode_in   = s1_mode_ff;
      s2_den_in    = s1_den_ff;
      s2_prod_a_in = PROD_W'(s1_op_a_ff) * PROD_W'(edge_gain_ff);
      s2_prod_b_in = PROD_W'(s1_op_b_ff) * PROD_W'(tex_gain_ff);
   end

   // ---------------------------------------------------------------- stage 3
   assign num_sum = {1'b0, s2_prod_a_ff} + {1'b0, s2_prod_b_ff};

   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_luma_in  = s2_luma_ff;
      s3_pos_in   = s2_pos_ff;
      s3_den_in   = s2_den_ff;
      if (s2_mode_ff == MODE_EDGE) begin
         s3_num_in = NUM_W'(edge_gain_ff);
      end else begin
         s3_num_in = num_sum[NUM_W-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 4
   assign scaled = SCALED_W'(s3_luma_ff) * SCALED_W'(s3_num_ff);

   always_comb begin
      pipe_valid_in[0]         = s3_valid_ff;
      pipe_side_in[0].luma     = s3_luma_ff;
      pipe_side_in[0].positive = s3_pos_ff;
      pipe_side_in[0].sticky   = |scaled[FRAC_W-1:0];
      pipe_side_in[0].den      = s3_den_ff;
      div_in[0].rem            = scaled[SCALED_W-1:FRAC_W];
      div_in[0].quot           = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         pipe_valid_ff[0] <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         s3_valid_ff      <= s3_valid_in;
         pipe_valid_ff[0] <= pipe_valid_in[0];
      end
      s1_luma_ff      <= s1_luma_in;
      s1_pos_ff       <= s1_pos_in;
      s1_mode_ff      <= s1_mode_in;
      s1_op_a_ff      <= s1_op_a_in;
      s1_op_b_ff      <= s1_op_b_in;
      s1_den_ff       <= s1_den_in;
      s2_luma_ff      <= s2_luma_in;
      s2_pos_ff       <= s2_pos_in;
      s2_mode_ff      <= s2_mode_in;
      s2_den_ff       <= s2_den_in;
      s2_prod_a_ff    <= s2_prod_a_in;
      s2_prod_b_ff    <= s2_prod_b_in;
      s3_luma_ff      <= s3_luma_in;
      s3_pos_ff       <= s3_pos_in;
      s3_den_ff       <= s3_den_in;
      s3_num_ff       <= s3_num_in;
      pipe_side_ff[0] <= pipe_side_in[0];
      div_ff[0]       <= div_in[0];
   end

   // ---------------------------------------------------------------- divider
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      always_comb begin
         pipe_valid_in[k+1] = pipe_valid_ff[k];
         pipe_side_in[k+1]  = pipe_side_ff[k];
         div_in[k+1]        = div_step2(div_ff[k], pipe_side_ff[k].den,
                                        QUOT_W - 1 - BITS_PER_STAGE * k);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_valid_ff[k+1] <= 1'b0;
         end else begin
            pipe_valid_ff[k+1] <= pipe_valid_in[k+1];
         end
         pipe_side_ff[k+1] <= pipe_side_in[k+1];
         div_ff[k+1]       <= div_in[k+1];
      end
   end

   // ---------------------------------------------------------------- clamp
   assign fin      = div_ff[DIV_STAGES];
   assign fin_side = pipe_side_ff[DIV_STAGES];
   assign inexact  = (fin.rem != '0) | fin_side.sticky;
   assign up_sum   = SUM_W'(fin_side.luma) + SUM_W'(fin.quot);
   assign down_amt = SUM_W'(fin.quot) + SUM_W'(inexact);

   always_comb begin
      out_valid_in = pipe_valid_ff[DIV_STAGES];
      if (fin_side.positive) begin
         if (up_sum > SUM_W'(LUMA_MAX)) begin
            out_luma_in = LUMA_MAX;
         end else begin
            out_luma_in = up_sum[LUMA_W-1:0];
         end
      end else begin
         if (SUM_W'(fin_side.luma) >= down_amt) begin
            out_luma_in = LUMA_W'(SUM_W'(fin_side.luma) - down_amt);
         end else begin
            out_luma_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_luma_ff <= out_luma_in;
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_enhanced_luma = out_luma_ff;

endmodule

@@ verif/edge_texture_gain_blend_checker.sv @@
// ----------------------------------------------------------------------------
// edge_texture_gain_blend_checker
// Watches the pixel, result and register ports of the edge/texture gain blend
// unit. Keeps its own copy of the four registers, works out the enhanced luma
// of every accepted pixel in exact integer arithmetic and compares each result
// in order. Register reads are checked against the same copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_texture_gain_blend_checker
   import etgb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [LUMA_W-1:0]        req_luma,
   input  logic signed [RESP_W-1:0] req_edge_response,
   input  logic                     rsp_strobe,
   input  logic [LUMA_W-1:0]        rsp_enhanced_luma,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [APB_ADDR_W-1:0]    paddr,
   input  logic [APB_DATA_W-1:0]    pwdata,
   input  logic [APB_DATA_W-1:0]    prdata,
   input  logic                     pready,
   output int                       pixels_in_flight,
   output int                       mismatch_count
);

   logic [THR_W-1:0]  edge_thr_copy;
   logic [THR_W-1:0]  texture_thr_copy;
   logic [GAIN_W-1:0] edge_gain_copy;
   logic [GAIN_W-1:0] texture_gain_copy;
   logic [LUMA_W-1:0] expected_luma_q[$];
   logic [LUMA_W-1:0] oldest_luma;

   initial begin
      mismatch_count   = 0;
      pixels_in_flight = 0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [LUMA_W-1:0] predict_enhanced_luma(
      input logic [LUMA_W-1:0] luma, input logic signed [RESP_W-1:0] resp);
      longint mag, et, tt, num, den, base, factor, prod, quot;
      mag = (resp < 0) ? -longint'(resp) : longint'(resp);
      et  = edge_thr_copy;
      tt  = texture_thr_copy;
      if (mag >= et) begin
         num = edge_gain_copy;
         den = 1;
      end else if (mag >= tt) begin
         num = (mag - tt) * edge_gain_copy + (et - mag) * texture_gain_copy;
         den = et - tt;
      end else if (tt != 0) begin
         num = mag * texture_gain_copy;
         den = tt;
      end else begin
         num = 0;
         den = 1;
      end
      base   = 1024 * den;
      factor = (resp > 0) ? base + num : base - num;
      prod   = longint'(luma) * factor;
      if (prod <= 0) return '0;
      quot = prod / base;
      return (quot > 255) ? LUMA_MAX : LUMA_W'(quot);
   endfunction

   function automatic logic [APB_DATA_W-1:0] register_copy(input logic [1:0] index);
      case (index)
         REG_EDGE_THR:    return APB_DATA_W'(edge_thr_copy);
         REG_TEXTURE_THR: return APB_DATA_W'(texture_thr_copy);
         REG_EDGE_GAIN:   return APB_DATA_W'(edge_gain_copy);
         default:         return APB_DATA_W'(texture_gain_copy);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_luma_q.delete();
         edge_thr_copy     = EDGE_THR_RESET;
         texture_thr_copy  = TEXTURE_THR_RESET;
         edge_gain_copy    = EDGE_GAIN_RESET;
         texture_gain_copy = TEXTURE_GAIN_RESET;
      end else begin
         if (rsp_strobe) begin
            if (expected_luma_q.size() == 0) begin
               report_mismatch("enhanced_luma with no pixel pending", rsp_enhanced_luma, -1);
            end else begin
               oldest_luma = expected_luma_q.pop_front();
               if (rsp_enhanced_luma !== oldest_luma)
                  report_mismatch("enhanced_luma", rsp_enhanced_luma, oldest_luma);
            end
         end
         if (start && !busy)
            expected_luma_q.push_back(predict_enhanced_luma(req_luma, req_edge_response));
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[3:2])
                  REG_EDGE_THR:    edge_thr_copy     = pwdata[THR_W-1:0];
                  REG_TEXTURE_THR: texture_thr_copy  = pwdata[THR_W-1:0];
                  REG_EDGE_GAIN:   edge_gain_copy    = pwdata[GAIN_W-1:0];
                  REG_TEXTURE_GAIN: texture_gain_copy = pwdata[GAIN_W-1:0];
                  default: ;
               endcase
            end else if (prdata !== register_copy(paddr[3:2])) begin
               report_mismatch("register read", prdata, register_copy(paddr[3:2]));
            end
         end
      end
      pixels_in_flight <= expected_luma_q.size();
   end

endmodule

@@ verif/tb_edge_texture_gain_blend_unit.sv @@
// ----------------------------------------------------------------------------
// tb_edge_texture_gain_blend_unit
// Drives pixels into the edge/texture gain blend unit in random bursts under a
// sequence of register settings, from reset values through the extremes of
// thresholds and strengths, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_edge_texture_gain_blend_unit;
   import etgb_pkg::*;

   localparam int NUM_DIRECTED    = 22;
   localparam int NUM_PHASES      = 12;
   localparam int NUM_FIXED       = 7;
   localparam int ITEMS_PER_PHASE = 44;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_GUARD     = 30;

   localparam int DIR_LUMA [NUM_DIRECTED] = '{0, 255, 255, 255, 128, 200, 200, 100, 100, 100,
                                              100, 100, 100, 255, 0, 0, 1, 255, 128, 77, 12, 255};
   localparam int DIR_RESP [NUM_DIRECTED] = '{0, 0, 2047, -2048, -2048, 1, -1, 15, 16, -16,
                                              63, 64, -63, -64, 2047, -2048, 40, 40, -40, 2046,
                                              -5, -1};
   localparam int FIX_EDGE_THR [NUM_FIXED]     = '{2047, 1, 0, 100, 300, 2047, 40};
   localparam int FIX_TEXTURE_THR [NUM_FIXED]  = '{0, 0, 5, 200, 300, 2047, 10};
   localparam int FIX_EDGE_GAIN [NUM_FIXED]    = '{4095, 0, 4095, 1000, 2048, 4095, 1536};
   localparam int FIX_TEXTURE_GAIN [NUM_FIXED] = '{0, 4095, 4095, 3000, 1024, 4095, 512};

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [LUMA_W-1:0]        req_luma;
   logic signed [RESP_W-1:0] req_edge_response;
   logic                     rsp_strobe;
   logic [LUMA_W-1:0]        rsp_enhanced_luma;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [APB_ADDR_W-1:0]    paddr;
   logic [APB_DATA_W-1:0]    pwdata;
   logic [APB_DATA_W-1:0]    prdata;
   logic                     pready;
   int                       pixels_in_flight;
   int                       mismatch_count;
   int                       idle_cycles;
   int                       edge_thr_now;
   int                       texture_thr_now;

   edge_texture_gain_blend_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_luma          (req_luma),
      .req_edge_response (req_edge_response),
      .rsp_strobe        (rsp_strobe),
      .rsp_enhanced_luma (rsp_enhanced_luma),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   edge_texture_gain_blend_checker pixel_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_luma          (req_luma),
      .req_edge_response (req_edge_response),
      .rsp_strobe        (rsp_strobe),
      .rsp_enhanced_luma (rsp_enhanced_luma),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .pixels_in_flight  (pixels_in_flight),
      .mismatch_count    (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [LUMA_W-1:0] luma, input logic signed [RESP_W-1:0] resp);
      start             <= 1'b1;
      req_luma          <= luma;
      req_edge_response <= resp;
      do @(posedge clock); while (busy);
   endtask

   task automatic register_access(input logic [1:0] index, input logic write,
                                  input logic [APB_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic read_back_registers();
      register_access(REG_EDGE_THR, 1'b0, '0);
      register_access(REG_TEXTURE_THR, 1'b0, '0);
      register_access(REG_EDGE_GAIN, 1'b0, '0);
      register_access(REG_TEXTURE_GAIN, 1'b0, '0);
   endtask

   task automatic apply_settings(input int edge_thr, input int texture_thr,
                                 input int edge_gain, input int texture_gain);
      register_access(REG_EDGE_THR, 1'b1, APB_DATA_W'(edge_thr));
      register_access(REG_TEXTURE_THR, 1'b1, APB_DATA_W'(texture_thr));
      register_access(REG_EDGE_GAIN, 1'b1, APB_DATA_W'(edge_gain));
      register_access(REG_TEXTURE_GAIN, 1'b1, APB_DATA_W'(texture_gain));
      edge_thr_now    = edge_thr;
      texture_thr_now = texture_thr;
      read_back_registers();
   endtask

   // hold off until every pixel in the pipe has come out
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pixels_in_flight != 0) @(posedge clock);
   endtask

   function automatic logic [LUMA_W-1:0] pick_luma();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return LUMA_MAX;
         default: return LUMA_W'($urandom_range(0, 255));
      endcase
   endfunction

   // steer magnitudes onto the threshold boundaries half of the time
   function automatic logic signed [RESP_W-1:0] pick_response();
      int mag;
      case ($urandom_range(0, 3))
         0:       return RESP_W'($urandom_range(0, 4095));
         1:       mag = edge_thr_now + $urandom_range(0, 8) - 4;
         2:       mag = texture_thr_now + $urandom_range(0, 8) - 4;
         default: mag = $urandom_range(0, 31);
      endcase
      if (mag < 0) mag = 0;
      if (mag >= 2048) return RESP_W'(-2048);
      return $urandom_range(0, 1) ? RESP_W'(-mag) : RESP_W'(mag);
   endfunction

   initial begin
      bit gaps_on;
      int burst_left;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_luma          <= '0;
      req_edge_response <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      idle_cycles       <= 0;
      edge_thr_now      = EDGE_THR_RESET;
      texture_thr_now   = TEXTURE_THR_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back_registers();
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_pixel(LUMA_W'(DIR_LUMA[i]), RESP_W'(DIR_RESP[i]));
      drain_pipeline();
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < NUM_FIXED)
            apply_settings(FIX_EDGE_THR[p], FIX_TEXTURE_THR[p],
                           FIX_EDGE_GAIN[p], FIX_TEXTURE_GAIN[p]);
         else
            apply_settings($urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 4095), $urandom_range(0, 4095));
         gaps_on    = (p % 3 != 2);
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (gaps_on && burst_left <= 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
               burst_left = $urandom_range(1, 24);
            end
            send_pixel(pick_luma(), pick_response());
            burst_left--;
         end
         drain_pipeline();
      end
      repeat (DRAIN_GUARD) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ edge_texture_gain_blend_unit.f @@
rtl/core/etgb_pkg.sv
rtl/core/edge_texture_gain_blend_unit.sv
verif/edge_texture_gain_blend_checker.sv
verif/tb_edge_texture_gain_blend_unit.sv
